FILE: sv/hmng_pkg.sv
// shared constants and types of the heightmap normal map generator
// no dependencies; imported by hmng_norm and the top level
package hmng_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_W = 12;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam logic [17:0] DZ_SQ    = 18'd16129;
    localparam logic [6:0]  N_SCALE  = 7'd127;
    localparam logic [14:0] NZ_NUM   = 15'd32385;
    localparam logic [7:0]  N_OFFSET = 8'd127;
    localparam logic [7:0]  BORDER_Z = 8'd255;

    typedef struct packed {
        logic              start;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
    } t_norm_req;

    typedef struct packed {
        logic       done;
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
    } t_norm_rsp;

endpackage

FILE: sv/hmng_norm.sv
// normal vector unit: ceiling square root and three shared-divisor divisions
// iterative, one root bit or one quotient bit per cycle; uses hmng_pkg
module hmng_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hmng_pkg::t_norm_req i_req,
    output hmng_pkg::t_norm_rsp o_rsp
);
    import hmng_pkg::*;

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SQRT = 3'd1;
    localparam logic [2:0] P_FIX  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_DONE = 3'd4;

    logic [2:0]  r_state;
    logic [17:0] r_s;
    logic [9:0]  r_b;
    logic [3:0]  r_k;
    logic        r_neg_x, r_neg_y;
    logic [14:0] r_num [3];
    logic [8:0]  r_rem [3];

    logic [8:0]  mag_x, mag_y;
    logic [17:0] sq_x, sq_y;
    logic [9:0]  t_b;
    logic [19:0] t_sq, b_sq;
    logic [9:0]  shifted [3];
    logic        qbit [3];

    assign mag_x = i_req.dx[8] ? 9'(-i_req.dx) : 9'(i_req.dx);
    assign mag_y = i_req.dy[8] ? 9'(-i_req.dy) : 9'(i_req.dy);
    assign sq_x  = 18'(mag_x) * 18'(mag_x);
    assign sq_y  = 18'(mag_y) * 18'(mag_y);
    assign t_b   = r_b | (10'd1 << r_k);
    assign t_sq  = 20'(t_b) * 20'(t_b);
    assign b_sq  = 20'(r_b) * 20'(r_b);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i] = {r_rem[i], r_num[i][14]};
            qbit[i]    = shifted[i] >= r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            case (r_state)
                P_IDLE: if (i_req.start) r_state <= P_SQRT;
                P_SQRT: if (r_k == 4'd0) r_state <= P_FIX;
                P_FIX:  r_state <= P_DIV;
                P_DIV:  if (r_k == 4'd0) r_state <= P_DONE;
                P_DONE: r_state <= P_IDLE;
                default: r_state <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            P_IDLE: begin
                r_s     <= sq_x + sq_y + DZ_SQ;
                r_b     <= 10'd0;
                r_k     <= 4'd9;
                r_neg_x <= i_req.dx[8];
                r_neg_y <= i_req.dy[8];
                r_num[0] <= 15'(mag_x) * 15'(N_SCALE);
                r_num[1] <= 15'(mag_y) * 15'(N_SCALE);
                r_num[2] <= NZ_NUM;
                for (int i = 0; i < 3; i++) r_rem[i] <= 9'd0;
            end
            P_SQRT: begin
                if (t_sq <= 20'(r_s)) r_b <= t_b;
                r_k <= r_k - 4'd1;
            end
            P_FIX: begin
                if (b_sq < 20'(r_s)) r_b <= r_b + 10'd1;
                r_k <= 4'd14;
            end
            P_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= qbit[i] ? 9'(shifted[i] - r_b) : shifted[i][8:0];
                    r_num[i] <= {r_num[i][13:0], qbit[i]};
                end
                r_k <= r_k - 4'd1;
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_state == P_DONE;
    assign o_rsp.nx   = r_neg_x ? N_OFFSET - r_num[0][7:0] : N_OFFSET + r_num[0][7:0];
    assign o_rsp.ny   = r_neg_y ? N_OFFSET - r_num[1][7:0] : N_OFFSET + r_num[1][7:0];
    assign o_rsp.nz   = r_num[2][7:0];

endmodule

FILE: sv/heightmap_normal_map_generator_unit.sv
// heightmap to normal map: luma line buffers in one memory, normals from hmng_norm
// uses hmng_pkg and hmng_norm
// a pixel passes S_LUMA, S_RD1, S_RD2 and S_RD3, then S_CALC for an interior word, then S_EMIT1
// one pixel at a time: the next pixel is taken only back in S_IDLE
// hmng_norm does a 10-step root and a 15-step division; S_EMIT2 sends a second word on the last row
// reset: counters, sizes (to their maxima) and handshakes clear; line buffer is not cleared
module heightmap_normal_map_generator_unit #(
    parameter int MAX_WIDTH  = hmng_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hmng_pkg::DEF_MAX_HEIGHT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_addr,
    input  logic [hmng_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [23:0]              i_s_tdata,  // red, green, blue
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [47:0]              o_m_tdata,  // pixel_row, pixel_col, normal_x, normal_y, normal_z, pad
    output logic                     o_m_tlast
);
    import hmng_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WVW = $clog2(MAX_WIDTH + 1);
    localparam int HVW = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LUMA  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_RD3   = 3'd4;
    localparam logic [2:0] S_CALC  = 3'd5;
    localparam logic [2:0] S_EMIT1 = 3'd6;
    localparam logic [2:0] S_EMIT2 = 3'd7;

    logic [7:0] mem [2**(CW+1)];
    logic [7:0] r_rd_data;
    logic [CW:0] rd_addr;

    logic [2:0]     r_state, n_state;
    logic [WVW-1:0] r_w;
    logic [HVW-1:0] r_h;
    logic [CW-1:0]  r_col_cnt;
    logic [RW-1:0]  r_row_cnt;
    logic           r_sel_cnt;

    logic [23:0]   r_rgb;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_sel;
    logic          r_has1, r_has2, r_inner;
    logic [7:0]    r_y, r_left, r_right;
    logic [7:0]    r_nx, r_ny, r_nz;

    logic        r_m_tvalid, r_m_tlast;
    logic [47:0] r_m_tdata;

    t_norm_req norm_req;
    t_norm_rsp norm_rsp;

    logic        accept, out_free, col_end, row_end;
    logic [31:0] cfg32, row32, col32;
    logic [23:0] luma_sum;
    logic [7:0]  bx, by, bz;
    logic        emit_last;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign col_end  = WVW'(r_col_cnt) + WVW'(1) >= r_w;
    assign row_end  = HVW'(r_row_cnt) + HVW'(1) >= r_h;
    assign cfg32    = 32'(i_cfg_wdata);
    assign luma_sum = 24'(r_rgb[7:0]) * 24'(W_RED) + 24'(r_rgb[15:8]) * 24'(W_GREEN)
                    + 24'(r_rgb[23:16]) * 24'(W_BLUE);

    always_comb begin
        case (r_state)
            S_LUMA:  rd_addr = {r_sel, r_col - CW'(1)};
            S_RD1:   rd_addr = {r_sel, r_col + CW'(1)};
            default: rd_addr = {~r_sel, r_col};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        if (r_state == S_RD3) mem[{~r_sel, r_col}] <= r_y;
    end

    // configuration and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WVW'(MAX_WIDTH);
            r_h       <= HVW'(MAX_HEIGHT);
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_sel_cnt <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_IMAGE_WIDTH) begin
                if (cfg32 == 32'd0) r_w <= WVW'(1);
                else if (cfg32 > 32'(MAX_WIDTH)) r_w <= WVW'(MAX_WIDTH);
                else r_w <= WVW'(cfg32);
            end else begin
                if (cfg32 == 32'd0) r_h <= HVW'(1);
                else if (cfg32 > 32'(MAX_HEIGHT)) r_h <= HVW'(MAX_HEIGHT);
                else r_h <= HVW'(cfg32);
            end
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_sel_cnt <= 1'b0;
        end else if (accept) begin
            if (col_end) begin
                r_col_cnt <= '0;
                r_sel_cnt <= ~r_sel_cnt;
                r_row_cnt <= row_end ? '0 : r_row_cnt + RW'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_LUMA;
            S_LUMA:  n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = (r_has1 && r_inner) ? S_CALC : S_EMIT1;
            S_CALC:  if (norm_rsp.done) n_state = S_EMIT1;
            S_EMIT1: begin
                if (!r_has1) n_state = r_has2 ? S_EMIT2 : S_IDLE;
                else if (out_free) n_state = r_has2 ? S_EMIT2 : S_IDLE;
            end
            S_EMIT2: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rgb   <= i_s_tdata;
            r_col   <= r_col_cnt;
            r_row   <= r_row_cnt;
            r_sel   <= r_sel_cnt;
            r_has1  <= r_row_cnt != '0;
            r_has2  <= row_end;
            r_inner <= r_row_cnt > RW'(1) && r_col_cnt != '0 && !col_end;
        end
        case (r_state)
            S_LUMA: r_y     <= luma_sum[23:16];
            S_RD1:  r_left  <= r_rd_data;
            S_RD2:  r_right <= r_rd_data;
            default: ;
        endcase
        if (norm_rsp.done) begin
            r_nx <= norm_rsp.nx;
            r_ny <= norm_rsp.ny;
            r_nz <= norm_rsp.nz;
        end
    end

    assign norm_req.start = r_state == S_RD3 && r_has1 && r_inner;
    assign norm_req.dx    = $signed({1'b0, r_left}) - $signed({1'b0, r_right});
    assign norm_req.dy    = $signed({1'b0, r_rd_data}) - $signed({1'b0, r_y});

    hmng_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_rsp   (norm_rsp)
    );

    // result word builder
    always_comb begin
        col32 = 32'(r_col);
        if (r_state == S_EMIT1) begin
            row32     = 32'(r_row) - 32'd1;
            emit_last = !r_has2;
            bx = r_inner ? r_nx : 8'd0;
            by = r_inner ? r_ny : 8'd0;
            bz = r_inner ? r_nz : BORDER_Z;
        end else begin
            row32     = 32'(r_row);
            emit_last = 1'b1;
            bx = 8'd0;
            by = 8'd0;
            bz = BORDER_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_m_tready) r_m_tvalid <= 1'b0;
            if (out_free && ((r_state == S_EMIT1 && r_has1) || r_state == S_EMIT2))
                r_m_tvalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && ((r_state == S_EMIT1 && r_has1) || r_state == S_EMIT2)) begin
            r_m_tdata <= {2'b00, bz, by, bx, col32[10:0], row32[10:0]};
            r_m_tlast <= emit_last;
        end
    end

    assign o_s_tready = r_state == S_IDLE && !i_cfg_we;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_rsp.done |-> r_state == S_CALC)
        else $error("normal unit finished outside the wait state");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("second pixel taken while one is at work");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WVW'(r_col_cnt) < r_w)
        else $error("column counter beyond image width");

    a_start_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_req.start |-> $past(r_state) == S_RD2)
        else $error("normal unit started before the line reads");

endmodule

FILE: tb/tb.sv
// testbench of heightmap_normal_map_generator_unit: pixel words in, normal words out
// checks every output word against a predictor of luma, line buffers and normal math
// uses hmng_pkg and the rtl of the unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hmng_pkg::*;

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] col;
        logic [7:0]  nx;
        logic [7:0]  ny;
        logic [7:0]  nz;
        logic        last;
    } t_normal;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         n_exp;
        t_normal    exp0;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;

    heightmap_normal_map_generator_unit u_dut (.*);

    // predictor state
    logic [7:0]  luma_mem [0:2*DEF_MAX_WIDTH-1];
    int unsigned cur_row, cur_col, line_sel, img_w, img_h;
    t_normal     normal_q[$];
    int          errors;
    int          quiet_cycles;
    int          send_idle_pct, recv_idle_pct;
    logic        hold_off;
    bit          test_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int ceil_root(int unsigned s);
        int unsigned b;
        b = 0;
        for (int k = 9; k >= 0; k--)
            if ((b | (1 << k)) * (b | (1 << k)) <= s) b = b | (1 << k);
        if (b * b < s) b++;
        return b;
    endfunction

    function automatic int trunc_div(int n, int d);
        if (n < 0) return -((-n) / d);
        return n / d;
    endfunction

    function automatic t_normal border_word(int unsigned r, int unsigned c);
        t_normal t;
        t.row = r[10:0];
        t.col = c[10:0];
        t.nx = 8'd0;
        t.ny = 8'd0;
        t.nz = BORDER_Z;
        t.last = 1'b0;
        return t;
    endfunction

    // returns number of words queued
    function automatic int predict_normals(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
        int unsigned w, h, prv, cur, y;
        int dx, dy, base, n;
        t_normal t;
        w = clamp_size(img_w, DEF_MAX_WIDTH);
        h = clamp_size(img_h, DEF_MAX_HEIGHT);
        prv = line_sel * DEF_MAX_WIDTH;
        cur = (line_sel ^ 1) * DEF_MAX_WIDTH;
        y = (13933 * r8 + 46871 * g8 + 4732 * b8) >> 16;
        if (y > 255) y = 255;
        n = 0;
        if (cur_row >= 1) begin
            if (cur_row == 1 || cur_col == 0 || cur_col + 1 >= w) begin
                t = border_word(cur_row - 1, cur_col);
            end else begin
                dx = int'(luma_mem[prv + cur_col - 1]) - int'(luma_mem[prv + cur_col + 1]);
                dy = int'(luma_mem[cur + cur_col]) - int'(y);
                base = ceil_root(dx * dx + dy * dy + 16129);
                t.row = 11'(cur_row - 1);
                t.col = cur_col[10:0];
                t.nx = 8'(trunc_div(dx * 127, base) + 127);
                t.ny = 8'(trunc_div(dy * 127, base) + 127);
                t.nz = 8'(32385 / base);
                t.last = 1'b0;
            end
            normal_q.push_back(t);
            n++;
        end
        if (cur_row + 1 >= h) begin
            normal_q.push_back(border_word(cur_row, cur_col));
            n++;
        end
        if (n > 0) normal_q[$].last = 1'b1;
        luma_mem[cur + cur_col] = y[7:0];
        if (cur_col + 1 >= w) begin
            cur_col = 0;
            line_sel ^= 1;
            cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
        return n;
    endfunction

    // valid stays high after the accept; the next call or the caller drops it
    task automatic send_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8, output int n);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {b8, g8, r8};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n = predict_normals(r8, g8, b8);
    endtask

    task automatic drain_and_settle();
        i_s_tvalid <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_size(logic [0:0] idx, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) img_w = v & 12'hFFF;
        else img_h = v & 12'hFFF;
        cur_row = 0;
        cur_col = 0;
        line_sel = 0;
    endtask

    task automatic set_image(int unsigned w, int unsigned h);
        drain_and_settle();
        write_size(REG_IMAGE_WIDTH, w);
        write_size(REG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    // run random pixels from the start of a frame, mostly smooth content with some noise
    task automatic random_frames(int unsigned w, int unsigned h, int n_pix);
        int n;
        logic [7:0] v;
        set_image(w, h);
        v = 8'($urandom);
        for (int k = 0; k < n_pix; k++) begin
            if ($urandom_range(3, 0) == 0) v = 8'($urandom);
            else v = v + 8'($urandom_range(40, 0)) - 8'd20;
            if ($urandom_range(4, 0) == 0)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), n);
            else
                send_pixel(v, v, v, n);
        end
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_normal got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[10:0], o_m_tdata[21:11], o_m_tdata[29:22],
                   o_m_tdata[37:30], o_m_tdata[45:38], o_m_tlast};
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = normal_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= !hold_off &&
                      !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !test_done) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_row dir[$];
        t_row e;
        int n;
        logic [7:0] v;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        test_done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_IMAGE_WIDTH;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        img_w = DEF_MAX_WIDTH;
        img_h = DEF_MAX_HEIGHT;
        cur_row = 0;
        cur_col = 0;
        line_sel = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one row of width 0 (taken as 1), then 3x3 and a 4x4 frame of extremes
        set_image(0, 1);
        e.r = 8'hFF; e.g = 8'hFF; e.b = 8'hFF; e.n_exp = 1;
        e.exp0 = border_word(0, 0);
        e.exp0.last = 1'b1;
        dir.push_back(e);
        e.r = 8'h00; e.g = 8'h00; e.b = 8'h00;
        dir.push_back(e);
        foreach (dir[k]) begin
            send_pixel(dir[k].r, dir[k].g, dir[k].b, n);
            if (n != dir[k].n_exp || normal_q[$] !== dir[k].exp0) begin
                $display("%0t: mismatch expected %h actual %h", $time, dir[k].exp0, normal_q[$]);
                errors++;
            end
        end
        set_image(3, 3);
        for (int k = 0; k < 9; k++)
            send_pixel((k == 4) ? 8'hFF : 8'h00, (k % 2) ? 8'hFF : 8'h00, 8'hAA, n);
        set_image(4, 4);
        for (int k = 0; k < 16; k++) begin
            v = (k[0] ^ k[2]) ? 8'hFF : 8'h00;
            send_pixel(v, v, v, n);
        end
        // oversize width saturates; height register rewrite restarts frame
        set_image(12'hFFF, 2);
        for (int k = 0; k < 20; k++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), n);
        set_image(5, 12'hFFF);
        for (int k = 0; k < 20; k++) send_pixel(8'h55, 8'hAA, 8'($urandom), n);

        // random phases with idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 26) : 0;
            recv_idle_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 78 : 26) : 0;
            random_frames($urandom_range(8, 3), $urandom_range(6, 2), 200);
            random_frames(1, $urandom_range(5, 1), 30);
            random_frames($urandom_range(20, 1), 1, 40);
            random_frames($urandom_range(30, 10), $urandom_range(8, 3), 150);
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // long receiver hold-off while pixels keep coming
        set_image(6, 5);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 90; k++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), n);
        join
        random_frames(2048, 1, 64);
        i_s_tvalid <= 1'b0;

        fork
            begin
                while (normal_q.size() != 0) @(posedge i_clk);
                repeat (60) @(posedge i_clk);
            end
            begin
                repeat (200000) @(posedge i_clk);
                errors++;
            end
        join_any
        disable fork;
        test_done = 1'b1;
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
